### src/dead_reckoning_position_observer_assert.svh
// ----------------------------------------------------------------------------
// dead reckoning observer assertion macros
// concurrent property wrappers used by the rtl that checks itself
// ----------------------------------------------------------------------------
`ifndef DEAD_RECKONING_POSITION_OBSERVER_ASSERT_SVH
`define DEAD_RECKONING_POSITION_OBSERVER_ASSERT_SVH

// same-cycle implication
`define DRPO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("drpo check failed");

// next-cycle implication
`define DRPO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("drpo check failed");

`endif

### src/drpo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpo_pkg
// types, constants and the cordic arctangent table of the position observer
// ----------------------------------------------------------------------------
package drpo_pkg;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ROT  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	localparam int ATAN_LEN = 24;
	localparam int CNT_W    = 5;
	localparam int XY_W     = 34;
	localparam int MA_W     = 34;
	localparam int MB_W     = 24;
	localparam int PROD_W   = MA_W + MB_W;
	localparam int POS_W    = 36;

	localparam logic [31:0] CORDIC_K = 32'd652032874;
	localparam logic [15:0] GAIN_RESET = 16'd32768;

	// multiply sequence steps
	localparam logic [CNT_W-1:0] MS_COS  = 5'd0;
	localparam logic [CNT_W-1:0] MS_VXC  = 5'd1;
	localparam logic [CNT_W-1:0] MS_VYS  = 5'd2;
	localparam logic [CNT_W-1:0] MS_VXS  = 5'd3;
	localparam logic [CNT_W-1:0] MS_VYC  = 5'd4;
	localparam logic [CNT_W-1:0] MS_HEAD = 5'd5;
	localparam logic [CNT_W-1:0] MS_GX   = 5'd6;
	localparam logic [CNT_W-1:0] MS_GY   = 5'd7;
	localparam logic [CNT_W-1:0] MS_LAST = 5'd8;

	function automatic logic [31:0] atan_val(input logic [CNT_W-1:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2FA;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

### src/dead_reckoning_position_observer.sv
// accepts an item only in ST_IDLE, so a new item waits until the last estimate
//   is loaded into the output registers; the work is done by the shared cordic
//   shift-add stage (one step a cycle) and the one shared multiplier (7 products)
// reset: arst_n clears position and heading to zero, gain to 1.0, no item pending
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dead_reckoning_position_observer
// rotates body-frame displacement by the stored heading, integrates heading
// and pulls the predicted position toward the measured one
// ----------------------------------------------------------------------------
`include "dead_reckoning_position_observer_assert.svh"

module dead_reckoning_position_observer #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  meas_x,
	input  logic signed [31:0]  meas_y,
	input  logic signed [23:0]  vel_x,
	input  logic signed [23:0]  vel_y,
	input  logic signed [23:0]  yaw_rate,
	input  logic [15:0]         step_time,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  est_x,
	output logic signed [31:0]  est_y,
	output logic signed [15:0]  est_heading
);

	localparam int STEPS = (CORDIC_STEPS > drpo_pkg::ATAN_LEN) ?
		drpo_pkg::ATAN_LEN : CORDIC_STEPS;
	localparam int UP = 32 - ANGLE_BITS;
	localparam int XW = drpo_pkg::XY_W;
	localparam int PW = drpo_pkg::PROD_W;
	localparam int SW = drpo_pkg::POS_W;
	localparam logic [drpo_pkg::CNT_W-1:0] ROT_LAST = drpo_pkg::CNT_W'(STEPS - 1);

	drpo_pkg::state_t state_q;
	logic [drpo_pkg::CNT_W-1:0] cnt_q;

	logic [15:0]               gain_q;
	logic signed [31:0]        pos_x_q, pos_y_q;
	logic [ANGLE_BITS-1:0]     heading_q;

	logic signed [31:0]        mx_q, my_q;
	logic signed [23:0]        vx_q, vy_q, wz_q;
	logic [15:0]               dt_q;

	logic signed [XW-1:0]      x_q, y_q, z_q;
	logic                      flip_q;
	logic signed [31:0]        cos_q, sin_q;

	logic signed [drpo_pkg::MA_W-1:0] mul_a;
	logic signed [drpo_pkg::MB_W-1:0] mul_b;
	logic signed [PW-1:0]      prod_q, acc_q;
	logic signed [PW-1:0]      rsum, rsh, corr;
	logic signed [SW-1:0]      px_q, py_q;
	logic signed [SW-1:0]      diff;

	logic signed [31:0]        est_x_q, est_y_q;
	logic [ANGLE_BITS-1:0]     est_head_q;
	logic                      out_valid_q;

	logic                      in_acc;
	logic                      out_load;
	logic [31:0]               ang32;
	logic                      flip;
	logic signed [XW-1:0]      z_init, xs, ys, atan34, c_fin, s_fin;

	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
		logic signed [31:0] r;
		if (v > SW'(32'sh7FFFFFFF))
			r = 32'sh7FFFFFFF;
		else if (v < -SW'(33'sh080000000))
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	assign in_ready = (state_q == drpo_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == drpo_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// cordic start angle, turned by a half turn around pi
	assign ang32  = {heading_q, UP'(0)};
	assign flip   = ang32[31] ^ ang32[30];
	assign z_init = {{(XW-31){ang32[31] ^ flip}}, ang32[30:0]};
	assign xs     = x_q >>> cnt_q;
	assign ys     = y_q >>> cnt_q;
	assign atan34 = {{(XW-32){1'b0}}, drpo_pkg::atan_val(cnt_q)};
	assign c_fin  = flip_q ? -x_q : x_q;
	assign s_fin  = flip_q ? -y_q : y_q;

	always_comb begin
		diff  = '0;
		mul_a = '0;
		mul_b = '0;
		case (cnt_q)
			drpo_pkg::MS_VXC: begin
				mul_a = {{2{cos_q[31]}}, cos_q};
				mul_b = vx_q;
			end
			drpo_pkg::MS_VYS: begin
				mul_a = {{2{sin_q[31]}}, sin_q};
				mul_b = vy_q;
			end
			drpo_pkg::MS_VXS: begin
				mul_a = {{2{sin_q[31]}}, sin_q};
				mul_b = vx_q;
			end
			drpo_pkg::MS_VYC: begin
				mul_a = {{2{cos_q[31]}}, cos_q};
				mul_b = vy_q;
			end
			drpo_pkg::MS_HEAD: begin
				mul_a = {{(drpo_pkg::MA_W-16){1'b0}}, dt_q};
				mul_b = wz_q;
			end
			drpo_pkg::MS_GX: begin
				diff  = {{(SW-32){mx_q[31]}}, mx_q} - px_q;
				mul_a = diff[drpo_pkg::MA_W-1:0];
				mul_b = {{(drpo_pkg::MB_W-16){1'b0}}, gain_q};
			end
			drpo_pkg::MS_GY: begin
				diff  = {{(SW-32){my_q[31]}}, my_q} - py_q;
				mul_a = diff[drpo_pkg::MA_W-1:0];
				mul_b = {{(drpo_pkg::MB_W-16){1'b0}}, gain_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign rsum = (cnt_q == drpo_pkg::MS_VXS) ? (acc_q - prod_q) : (acc_q + prod_q);
	assign rsh  = rsum >>> 30;
	assign corr = prod_q >>> 15;

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drpo_pkg::ST_IDLE;
			cnt_q       <= '0;
			gain_q      <= drpo_pkg::GAIN_RESET;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			heading_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				gain_q <= cfg_wr_data;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				drpo_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc)
						state_q <= drpo_pkg::ST_ROT;
				end
				drpo_pkg::ST_ROT: begin
					if (cnt_q == ROT_LAST) begin
						cnt_q   <= drpo_pkg::MS_COS;
						state_q <= drpo_pkg::ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				drpo_pkg::ST_MUL: begin
					if (cnt_q == drpo_pkg::MS_GX)
						heading_q <= heading_q + prod_q[UP +: ANGLE_BITS];
					if (cnt_q == drpo_pkg::MS_LAST)
						state_q <= drpo_pkg::ST_DONE;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				drpo_pkg::ST_DONE: begin
					if (out_load) begin
						pos_x_q <= sat32(px_q);
						pos_y_q <= sat32(py_q);
						state_q <= drpo_pkg::ST_IDLE;
					end
				end
				default: state_q <= drpo_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mx_q   <= meas_x;
			my_q   <= meas_y;
			vx_q   <= vel_x;
			vy_q   <= vel_y;
			wz_q   <= yaw_rate;
			dt_q   <= step_time;
			x_q    <= XW'(drpo_pkg::CORDIC_K);
			y_q    <= '0;
			z_q    <= z_init;
			flip_q <= flip;
		end
		if (state_q == drpo_pkg::ST_ROT) begin
			if (!z_q[XW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan34;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan34;
			end
		end
		if (state_q == drpo_pkg::ST_MUL) begin
			prod_q <= mul_a * mul_b;
			case (cnt_q)
				drpo_pkg::MS_COS: begin
					cos_q <= c_fin[31:0];
					sin_q <= s_fin[31:0];
				end
				drpo_pkg::MS_VYS: acc_q <= prod_q;
				drpo_pkg::MS_VXS: px_q <= {{(SW-32){pos_x_q[31]}}, pos_x_q} + rsh[SW-1:0];
				drpo_pkg::MS_HEAD: py_q <= {{(SW-32){pos_y_q[31]}}, pos_y_q} + rsh[SW-1:0];
				drpo_pkg::MS_GY: px_q <= px_q + corr[SW-1:0];
				drpo_pkg::MS_LAST: py_q <= py_q + corr[SW-1:0];
				default: acc_q <= (cnt_q == drpo_pkg::MS_VYC) ? prod_q : acc_q;
			endcase
		end
		if (out_load) begin
			est_x_q    <= sat32(px_q);
			est_y_q    <= sat32(py_q);
			est_head_q <= heading_q;
		end
	end

	assign out_valid = out_valid_q;
	assign est_x     = est_x_q;
	assign est_y     = est_y_q;

	generate
		if (ANGLE_BITS >= 16) begin : g_head_narrow
			assign est_heading = est_head_q[ANGLE_BITS-1 -: 16];
		end else begin : g_head_wide
			assign est_heading = {est_head_q, (16-ANGLE_BITS)'(0)};
		end
	endgenerate

	`DRPO_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, !in_ready)
	`DRPO_ASSERT_NOW(a_rot_count, clk, arst_n, state_q == drpo_pkg::ST_ROT, cnt_q <= ROT_LAST)
	`DRPO_ASSERT_NOW(a_result_from_done, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == drpo_pkg::ST_DONE)

endmodule

### tb/sv/dead_reckoning_position_observer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dead_reckoning_position_observer_checker
// watches the config port and both channels of the observer, keeps its own
// copy of position, heading and gain, predicts each estimate bit for bit and
// compares every delivered estimate with the oldest prediction
// ----------------------------------------------------------------------------
module dead_reckoning_position_observer_checker #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] meas_x,
	input  logic signed [31:0] meas_y,
	input  logic signed [23:0] vel_x,
	input  logic signed [23:0] vel_y,
	input  logic signed [23:0] yaw_rate,
	input  logic [15:0]        step_time,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] est_x,
	input  logic signed [31:0] est_y,
	input  logic signed [15:0] est_heading,
	output int                 mismatches,
	output int                 outstanding,
	output int                 checked
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] heading;
	} estimate_t;

	localparam int UP_SHIFT  = 32 - ANGLE_BITS;
	localparam int ROT_STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int H_DOWN    = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
	localparam int H_UP      = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
	localparam logic [31:0] HEADING_MASK = (32'h1 << ANGLE_BITS) - 32'h1;
	localparam logic [31:0] UNIT_GAIN    = 32'd652032874;

	localparam logic [0:23][31:0] ARCTAN = {
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	longint      pos_x;
	longint      pos_y;
	logic [31:0] heading_code;
	logic [15:0] gain;
	estimate_t   expected_q[$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
		checked     = 0;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : observe
		estimate_t   want;
		estimate_t   got;
		logic [31:0] ang;
		logic [31:0] turned;
		logic [31:0] h16;
		bit          flip;
		longint      rx, ry, rz, xs, ys, cs, sn;
		longint      mx, my, vx, vy, wz, dt, px, py, delta;
		if (!arst_n) begin
			pos_x        = 0;
			pos_y        = 0;
			heading_code = 32'h0;
			gain         = 16'd32768;
			expected_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				checked++;
				got.x       = est_x;
				got.y       = est_y;
				got.heading = est_heading;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("estimate %0d with none pending: x=%0d y=%0d heading=%0d",
							checked, got.x, got.y, got.heading);
				end else begin
					want = expected_q.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.heading !== want.heading) begin
						mismatches++;
						if (mismatches <= 10)
							$display("estimate %0d: expected x=%0d y=%0d heading=%0d, got x=%0d y=%0d heading=%0d",
								checked, want.x, want.y, want.heading, got.x, got.y, got.heading);
					end
				end
			end

			if (cfg_wr_en)
				gain = cfg_wr_data;

			if (in_valid && in_ready) begin
				mx = longint'(meas_x);
				my = longint'(meas_y);
				vx = longint'(vel_x);
				vy = longint'(vel_y);
				wz = longint'(yaw_rate);
				dt = longint'(step_time);

				// cordic on the heading as it stood before this item
				ang    = heading_code << UP_SHIFT;
				turned = ang + 32'h40000000;
				flip   = turned[31];
				if (flip)
					ang = ang - 32'h80000000;
				rx = longint'(UNIT_GAIN);
				ry = 0;
				rz = longint'($signed(ang));
				for (int i = 0; i < ROT_STEPS; i++) begin
					xs = rx >>> i;
					ys = ry >>> i;
					if (rz >= 0) begin
						rx = rx - ys;
						ry = ry + xs;
						rz = rz - longint'(ARCTAN[i]);
					end else begin
						rx = rx + ys;
						ry = ry - xs;
						rz = rz + longint'(ARCTAN[i]);
					end
				end
				cs = flip ? -rx : rx;
				sn = flip ? -ry : ry;

				px = pos_x + ((vx * cs - vy * sn) >>> 30);
				py = pos_y + ((vx * sn + vy * cs) >>> 30);

				delta        = (wz * dt) >>> UP_SHIFT;
				heading_code = (heading_code + delta[31:0]) & HEADING_MASK;

				px    = px + ((longint'(gain) * (mx - px)) >>> 15);
				py    = py + ((longint'(gain) * (my - py)) >>> 15);
				pos_x = clamp32(px);
				pos_y = clamp32(py);

				h16          = (heading_code >> H_DOWN) << H_UP;
				want.x       = pos_x[31:0];
				want.y       = pos_y[31:0];
				want.heading = h16[15:0];
				expected_q.push_back(want);
			end
		end
		outstanding = expected_q.size();
	end

endmodule

### tb/sv/dead_reckoning_position_observer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dead_reckoning_position_observer_tb
// drives directed and random fused updates through the observer under
// several correction gains, with bursty sender gaps and receiver stalls;
// the checker beside the block predicts and compares every estimate
// ----------------------------------------------------------------------------
module dead_reckoning_position_observer_tb;

	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int LATENCY      = CORDIC_STEPS + 10;
	localparam int LIMIT        = 600000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 125;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [15:0]        cfg_wr_data = 16'h0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic signed [31:0] meas_x      = 32'sh0;
	logic signed [31:0] meas_y      = 32'sh0;
	logic signed [23:0] vel_x       = 24'sh0;
	logic signed [23:0] vel_y       = 24'sh0;
	logic signed [23:0] yaw_rate    = 24'sh0;
	logic [15:0]        step_time   = 16'h0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic signed [31:0] est_x;
	logic signed [31:0] est_y;
	logic signed [15:0] est_heading;

	int mismatches;
	int outstanding;
	int checked;
	int cycles       = 0;
	int updates_sent = 0;
	int gains_used   = 0;
	int burst_left   = 0;
	int stall_mode   = 0;
	int mode_left    = 0;
	int hold_left    = 0;

	dead_reckoning_position_observer #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.ANGLE_BITS  (ANGLE_BITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.meas_x     (meas_x),
		.meas_y     (meas_y),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.yaw_rate   (yaw_rate),
		.step_time  (step_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.est_x      (est_x),
		.est_y      (est_y),
		.est_heading(est_heading)
	);

	dead_reckoning_position_observer_checker #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.ANGLE_BITS  (ANGLE_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.meas_x     (meas_x),
		.meas_y     (meas_y),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.yaw_rate   (yaw_rate),
		.step_time  (step_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.est_x      (est_x),
		.est_y      (est_y),
		.est_heading(est_heading),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(64, 512);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
		end else begin
			case (stall_mode)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= ($urandom_range(0, 3) != 0);
				end
				2: begin
					out_ready <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					out_ready <= ~out_ready;
					hold_left  = $urandom_range(1, out_ready ? 30 : 20);
				end
			endcase
		end
	end

	task automatic idle_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic drive_update(
		input logic signed [31:0] mx,
		input logic signed [31:0] my,
		input logic signed [23:0] vx,
		input logic signed [23:0] vy,
		input logic signed [23:0] wz,
		input logic [15:0]        dt
	);
		@(negedge clk);
		meas_x    <= mx;
		meas_y    <= my;
		vel_x     <= vx;
		vel_y     <= vy;
		yaw_rate  <= wz;
		step_time <= dt;
		in_valid  <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		updates_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 40);
			idle_sender($urandom_range(1, 20));
		end
	endtask

	task automatic wait_for_estimates();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic set_gain(input logic [15:0] g);
		wait_for_estimates();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= g;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		gains_used++;
	endtask

	function automatic logic [31:0] pick32(input int sel);
		case (sel)
			0:       return 32'h7FFFFFFF;
			1:       return 32'h80000000;
			2:       return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [23:0] pick24(input int sel);
		case (sel)
			0:       return 24'h7FFFFF;
			1:       return 24'h800000;
			2:       return 24'h0;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_update();
		int kind;
		logic signed [31:0] mx, my;
		logic signed [23:0] vx, vy, wz;
		logic [15:0] dt;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			// plausible motion near the origin
			mx = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
			my = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
			vx = 24'($signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000);
			vy = 24'($signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000);
			wz = 24'($urandom);
			dt = 16'($urandom);
		end else if (kind < 8) begin
			mx = $urandom;
			my = $urandom;
			vx = 24'($urandom);
			vy = 24'($urandom);
			wz = 24'($urandom);
			dt = 16'($urandom);
		end else begin
			mx = pick32($urandom_range(0, 3));
			my = pick32($urandom_range(0, 3));
			vx = pick24($urandom_range(0, 3));
			vy = pick24($urandom_range(0, 3));
			wz = pick24($urandom_range(0, 3));
			case ($urandom_range(0, 2))
				0:       dt = 16'hFFFF;
				1:       dt = 16'h0;
				default: dt = 16'($urandom);
			endcase
		end
		drive_update(mx, my, vx, vy, wz, dt);
	endtask

	initial begin : stimulus
		logic [15:0] g;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// unit gain after reset: estimate follows the measurement
		drive_update(32'sh0, 32'sh0, 24'sh0, 24'sh0, 24'sh0, 16'h0);
		drive_update(32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, 16'hFFFF);
		drive_update(-32'sh80000000, -32'sh80000000, -24'sh800000, 24'sh7FFFFF, -24'sh800000,
			16'hFFFF);
		// heading to a quarter turn, then to the half-turn wrap code
		drive_update(32'sh0, 32'sh0, 24'sh0, 24'sh0, 24'sh0, 16'h0);
		drive_update(32'sh10000, -32'sh10000, 24'sh7FFFFF, 24'sh0, 24'sh8000, 16'h8000);
		drive_update(32'sh20000, 32'sh20000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh8000, 16'h8000);
		drive_update(32'sh0, 32'sh0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh0, 16'h0);
		drive_update(32'sh0, 32'sh0, -24'sh800000, 24'sh0, -24'sh8000, 16'h8000);

		// zero gain: pure dead reckoning
		set_gain(16'd0);
		drive_update(32'sh7FFFFFFF, -32'sh80000000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF);
		drive_update(32'sh0, 32'sh0, 24'sh7FFFFF, -24'sh800000, 24'sh2000, 16'hFFFF);
		drive_update(32'sh0, 32'sh0, -24'sh800000, -24'sh800000, -24'sh800000, 16'h1);

		// gain well above one drives the estimate into saturation
		set_gain(16'hFFFF);
		drive_update(32'sh7FFFFFFF, -32'sh80000000, 24'sh0, 24'sh0, 24'sh0, 16'h0);
		drive_update(32'sh7FFFFFFF, -32'sh80000000, 24'sh7FFFFF, -24'sh800000, 24'sh0, 16'h0);
		drive_update(-32'sh80000000, 32'sh7FFFFFFF, -24'sh800000, 24'sh7FFFFF, 24'sh0, 16'h0);
		drive_update(-32'sh80000000, 32'sh7FFFFFFF, 24'sh0, 24'sh0, 24'sh7FFFFF, 16'hFFFF);

		set_gain(16'd16384);
		drive_update(32'sh00100000, -32'sh00100000, 24'sh010000, 24'sh008000, 24'sh4000, 16'h4000);
		drive_update(-32'sh00100000, 32'sh00100000, -24'sh010000, 24'sh008000, 24'sh4000, 16'h4000);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       g = 16'd32768;
				1:       g = 16'($urandom_range(0, 32768));
				2:       g = 16'hFFFF;
				3:       g = 16'd1;
				4:       g = 16'($urandom);
				5:       g = 16'd32767;
				6:       g = 16'd0;
				default: g = 16'($urandom_range(16384, 40000));
			endcase
			set_gain(g);
			repeat (PHASE_ITEMS) random_update();
		end

		wait_for_estimates();
		repeat (2 * LATENCY) @(negedge clk);
		$display("covered %0d updates under %0d gain settings, %0d estimates checked",
			updates_sent, gains_used, checked);
		if (mismatches == 0 && outstanding == 0)
			$display("** dead_reckoning_position_observer: PASSED **");
		else
			$display("** dead_reckoning_position_observer: FAILED **");
		$finish;
	end

	initial begin : watchdog
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timed out after %0d cycles", cycles);
		$display("** dead_reckoning_position_observer: FAILED **");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/drpo_pkg.sv
src/dead_reckoning_position_observer.sv
tb/sv/dead_reckoning_position_observer_checker.sv
tb/sv/dead_reckoning_position_observer_tb.sv
